FILE: hw/rtl/scs_pkg.sv
// Shared types and constants for the sentence chunk splitter.
package scs_pkg;

  localparam int POS_BITS = 24;
  localparam int LEN_BITS = 16;

  localparam logic [LEN_BITS-1:0] MAX_PIECE_RESET = 16'd256;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MAX_PIECE = 1'b0;

  localparam int FIFO_AW = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int FIFO_CW = FIFO_AW + 1;
  // two results per item, one item in the stage and one being accepted
  localparam int STALL_LEVEL = FIFO_DEPTH - 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [23:0]         piece_start;
    logic [LEN_BITS-1:0] piece_length;
    logic                piece_end_of_burst;
  } out_item_t;

  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t item0;
    out_item_t item1;
  } push_t;

endpackage

FILE: hw/rtl/scs_cfg.sv
// APB register file holding the piece length limit.
module scs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [scs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [scs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [scs_pkg::LEN_BITS-1:0]     max_piece_chars
);

  logic [scs_pkg::LEN_BITS-1:0] max_piece_r;
  logic [scs_pkg::LEN_BITS-1:0] max_piece_nxt;
  logic                         reg_idx;

  assign reg_idx = paddr[scs_pkg::CFG_ADDR_W-1];
  assign pready = 1'b1;
  assign max_piece_chars = max_piece_r;

  always_comb begin
    max_piece_nxt = max_piece_r;
    if (psel && penable && pwrite && reg_idx == scs_pkg::REG_MAX_PIECE) begin
      max_piece_nxt = pwdata[scs_pkg::LEN_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      scs_pkg::REG_MAX_PIECE: begin
        prdata = {{(scs_pkg::CFG_DATA_W-scs_pkg::LEN_BITS){1'b0}}, max_piece_r};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_piece_r <= scs_pkg::MAX_PIECE_RESET;
    end else begin
      max_piece_r <= max_piece_nxt;
    end
  end

endmodule

FILE: hw/rtl/scs_core.sv
// Input stage and per-byte sentence/window tracking that produces up to two pieces.
module scs_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  scs_pkg::in_item_t            item,
  input  logic [scs_pkg::LEN_BITS-1:0] max_piece_chars,
  output scs_pkg::push_t               push
);

  localparam int PB = scs_pkg::POS_BITS;
  localparam int LB = scs_pkg::LEN_BITS;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_E3     = 3'd1;
  localparam logic [2:0] M_E3_80  = 3'd2;
  localparam logic [2:0] M_E0     = 3'd3;
  localparam logic [2:0] M_E0_A5  = 3'd4;

  logic              stg_valid_r;
  scs_pkg::in_item_t stg_item_r;

  logic [PB-1:0] pos_r, pos_nxt;
  logic          wa_r, wa_nxt;
  logic [PB-1:0] ws_r, ws_nxt;
  logic [LB-1:0] fill_r, fill_nxt;
  logic          has_r, has_nxt;
  logic [LB-1:0] first_r, first_nxt;
  logic [LB-1:0] tend_r, tend_nxt;
  logic          lsv_r, lsv_nxt;
  logic [LB-1:0] lsp_r, lsp_nxt;
  logic [LB-1:0] ltb_r, ltb_nxt;
  logic [2:0]    match_r, match_nxt;
  logic          bp_r, bp_nxt;

  logic [7:0]    b;
  logic          sp;
  logic          term;
  logic [LB-1:0] lim;

  logic          ea_v, eb_v, ec_v;
  logic [PB-1:0] ea_s, eb_s, ec_s;
  logic [LB-1:0] ea_l, eb_l, ec_l;

  assign b   = stg_item_r.text_byte;
  assign sp  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  assign lim = (max_piece_chars == '0) ? LB'(1) : max_piece_chars;

  always_comb begin
    match_nxt = M_IDLE;
    term = 1'b0;
    if (match_r == M_E3 && b == 8'h80) begin
      match_nxt = M_E3_80;
    end else if (match_r == M_E3_80 && b == 8'h82) begin
      term = 1'b1;
    end else if (match_r == M_E0 && b == 8'hA5) begin
      match_nxt = M_E0_A5;
    end else if (match_r == M_E0_A5 && b == 8'hA4) begin
      term = 1'b1;
    end else if (b == 8'h2E || b == 8'h21 || b == 8'h3F) begin
      term = 1'b1;
    end else if (b == 8'hE3) begin
      match_nxt = M_E3;
    end else if (b == 8'hE0) begin
      match_nxt = M_E0;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    wa_nxt    = wa_r;
    ws_nxt    = ws_r;
    fill_nxt  = fill_r;
    has_nxt   = has_r;
    first_nxt = first_r;
    tend_nxt  = tend_r;
    lsv_nxt   = lsv_r;
    lsp_nxt   = lsp_r;
    ltb_nxt   = ltb_r;
    bp_nxt    = bp_r;
    ea_v = 1'b0;
    eb_v = 1'b0;
    ec_v = 1'b0;
    ea_s = '0;
    eb_s = '0;
    ec_s = '0;
    ea_l = '0;
    eb_l = '0;
    ec_l = '0;

    if (stg_valid_r) begin
      // sentence end confirmed by the blank that follows it
      if (bp_r && sp) begin
        ea_s = ws_nxt + {{(PB-LB){1'b0}}, first_nxt};
        ea_l = tend_nxt - first_nxt;
        ea_v = wa_nxt && has_nxt && (ea_l != '0);
        wa_nxt   = 1'b0;
        has_nxt  = 1'b0;
        lsv_nxt  = 1'b0;
        fill_nxt = '0;
      end

      if (!wa_nxt) begin
        if (!sp) begin
          wa_nxt    = 1'b1;
          ws_nxt    = pos_r;
          fill_nxt  = LB'(1);
          first_nxt = '0;
          has_nxt   = 1'b1;
          tend_nxt  = LB'(1);
          lsv_nxt   = 1'b0;
        end
      end else if (fill_nxt >= lim) begin
        if (!sp && lsv_nxt && lsp_nxt < fill_nxt) begin
          // split at the last blank, the word in flight moves to the new window
          eb_s = ws_nxt + {{(PB-LB){1'b0}}, first_nxt};
          eb_l = ltb_nxt - first_nxt;
          eb_v = has_nxt && (first_nxt < lsp_nxt) && (eb_l != '0);
          ws_nxt    = ws_nxt + {{(PB-LB){1'b0}}, lsp_nxt};
          fill_nxt  = fill_nxt - lsp_nxt + LB'(1);
          tend_nxt  = fill_nxt;
          first_nxt = LB'(1);
          has_nxt   = 1'b1;
          lsv_nxt   = 1'b0;
        end else begin
          eb_s = ws_nxt + {{(PB-LB){1'b0}}, first_nxt};
          eb_l = tend_nxt - first_nxt;
          eb_v = has_nxt && (eb_l != '0);
          wa_nxt    = 1'b1;
          ws_nxt    = pos_r;
          fill_nxt  = LB'(1);
          first_nxt = '0;
          has_nxt   = !sp;
          tend_nxt  = sp ? '0 : LB'(1);
          lsv_nxt   = 1'b0;
        end
      end else begin
        if (sp) begin
          if (fill_nxt >= LB'(2)) begin
            lsp_nxt = fill_nxt;
            ltb_nxt = tend_nxt;
            lsv_nxt = 1'b1;
          end
        end else begin
          if (!has_nxt) begin
            first_nxt = fill_nxt;
            has_nxt   = 1'b1;
          end
          tend_nxt = fill_nxt + LB'(1);
        end
        fill_nxt = fill_nxt + LB'(1);
      end

      bp_nxt  = term;
      pos_nxt = pos_r + PB'(1);

      if (stg_item_r.text_last) begin
        ec_s = ws_nxt + {{(PB-LB){1'b0}}, first_nxt};
        ec_l = tend_nxt - first_nxt;
        ec_v = wa_nxt && has_nxt && (ec_l != '0);
        pos_nxt   = '0;
        wa_nxt    = 1'b0;
        ws_nxt    = '0;
        fill_nxt  = '0;
        has_nxt   = 1'b0;
        first_nxt = '0;
        tend_nxt  = '0;
        lsv_nxt   = 1'b0;
        lsp_nxt   = '0;
        ltb_nxt   = '0;
        bp_nxt    = 1'b0;
      end
    end
  end

  // a sentence flush leaves no window, so it never pairs with another piece
  always_comb begin
    push.valid0 = ea_v || eb_v || ec_v;
    push.valid1 = eb_v && ec_v;
    push.item1.piece_start        = ec_s[23:0];
    push.item1.piece_length       = ec_l;
    push.item1.piece_end_of_burst = 1'b1;
    if (ea_v) begin
      push.item0.piece_start  = ea_s[23:0];
      push.item0.piece_length = ea_l;
    end else if (eb_v) begin
      push.item0.piece_start  = eb_s[23:0];
      push.item0.piece_length = eb_l;
    end else begin
      push.item0.piece_start  = ec_s[23:0];
      push.item0.piece_length = ec_l;
    end
    push.item0.piece_end_of_burst = !(eb_v && ec_v);
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      stg_item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      pos_r       <= '0;
      wa_r        <= 1'b0;
      ws_r        <= '0;
      fill_r      <= '0;
      has_r       <= 1'b0;
      first_r     <= '0;
      tend_r      <= '0;
      lsv_r       <= 1'b0;
      lsp_r       <= '0;
      ltb_r       <= '0;
      match_r     <= M_IDLE;
      bp_r        <= 1'b0;
    end else begin
      stg_valid_r <= item_valid;
      pos_r       <= pos_nxt;
      wa_r        <= wa_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      has_r       <= has_nxt;
      first_r     <= first_nxt;
      tend_r      <= tend_nxt;
      lsv_r       <= lsv_nxt;
      lsp_r       <= lsp_nxt;
      ltb_r       <= ltb_nxt;
      if (stg_valid_r) begin
        match_r <= stg_item_r.text_last ? M_IDLE : match_nxt;
      end
      bp_r        <= bp_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && stg_item_r.text_last |=> pos_r == '0 && !wa_r && !bp_r)
    else $error("state not cleared after final byte");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid0 |-> push.item0.piece_length != '0)
    else $error("empty piece pushed");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |=> pos_r == $past(pos_r) && wa_r == $past(wa_r))
    else $error("state moved without an item");

endmodule

FILE: hw/rtl/scs_fifo.sv
// Result queue taking up to two pieces per cycle and giving one per cycle while out_stall is low.
module scs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  scs_pkg::push_t     push,
  output logic               full_soon,
  output logic               out_valid,
  input  logic               out_stall,
  output scs_pkg::out_item_t out_item
);

  scs_pkg::out_item_t mem_r [scs_pkg::FIFO_DEPTH];

  logic [scs_pkg::FIFO_AW-1:0] wr_r, wr_nxt;
  logic [scs_pkg::FIFO_AW-1:0] rd_r, rd_nxt;
  logic [scs_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [scs_pkg::FIFO_CW-1:0] n_push;
  logic                        pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign full_soon = (count_r > scs_pkg::FIFO_CW'(scs_pkg::STALL_LEVEL));
  assign n_push    = scs_pkg::FIFO_CW'(push.valid0) + scs_pkg::FIFO_CW'(push.valid1);

  always_comb begin
    wr_nxt    = wr_r + n_push[scs_pkg::FIFO_AW-1:0];
    rd_nxt    = rd_r + scs_pkg::FIFO_AW'(pop);
    count_nxt = count_r + n_push - scs_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem_r[wr_r] <= push.item0;
    end
    if (push.valid1) begin
      mem_r[wr_r + scs_pkg::FIFO_AW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid0 |-> ({1'b0, count_r} + {1'b0, n_push}) <= (scs_pkg::FIFO_CW + 1)'(scs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> push.valid0)
    else $error("second piece without first");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && count_r == scs_pkg::FIFO_CW'(1) && !push.valid0 |=> !out_valid)
    else $error("queue not empty after last piece taken");

endmodule

FILE: hw/rtl/sentence_chunk_splitter.sv
// Top level of the sentence chunk splitter.
// Usage:
//   Input channel (in_valid/in_stall/in_item) takes one UTF-8 byte per item,
//   with text_last marking the final byte of a text. Result channel
//   (out_valid/out_stall/out_item) gives each trimmed piece as a start offset
//   and length; piece_end_of_burst marks the last piece caused by one byte.
//   An APB port sets max_piece_chars (address 0); write it only while idle.
//   An accepted item is registered in the input stage; its pieces go to the
//   result queue. Throughput: one byte per cycle unless in_stall, set by the
//   single input stage that updates the window state; a byte can give up to
//   two pieces and the result channel moves one piece per cycle, so in_stall
//   rises when the eight-entry result queue holds more than four pieces.
//   Reset clears all offsets and the queue and sets max_piece_chars to 256.
//   A stalled receiver holds the current piece; bytes keep flowing until the
//   queue fills past that level.
module sentence_chunk_splitter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scs_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scs_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                         in_accept;
  logic                         full_soon;
  logic [scs_pkg::LEN_BITS-1:0] max_piece_chars;
  scs_pkg::push_t               push;

  assign in_stall  = full_soon;
  assign in_accept = in_valid && !in_stall;

  scs_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_piece_chars (max_piece_chars)
  );

  scs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (in_accept),
    .item            (in_item),
    .max_piece_chars (max_piece_chars),
    .push            (push)
  );

  scs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full_soon (full_soon),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: test/tb_sentence_chunk_splitter.sv
// Self-checking testbench for the sentence chunk splitter: byte stream in, trimmed pieces out.
module tb_sentence_chunk_splitter;

  typedef enum int {TS_IDLE, TS_E3, TS_E3_80, TS_E0, TS_E0_A5} term_stage_t;
  typedef enum int {RX_FREE, RX_RANDOM, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_DOT   = 8'h2E;
  localparam logic [7:0] B_BANG  = 8'h21;
  localparam logic [7:0] B_QUERY = 8'h3F;
  localparam logic [7:0] B_E3    = 8'hE3;
  localparam logic [7:0] B_80    = 8'h80;
  localparam logic [7:0] B_82    = 8'h82;
  localparam logic [7:0] B_E0    = 8'hE0;
  localparam logic [7:0] B_A5    = 8'hA5;
  localparam logic [7:0] B_A4    = 8'hA4;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  scs_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_stall;
  scs_pkg::out_item_t             out_item;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [scs_pkg::CFG_ADDR_W-1:0] paddr;
  logic [scs_pkg::CFG_DATA_W-1:0] pwdata;
  logic [scs_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  sentence_chunk_splitter dut (.*);

  always #2 clk = ~clk;

  // predictor state
  int unsigned piece_cap = scs_pkg::MAX_PIECE_RESET;
  logic [23:0] next_pos;
  bit          win_open;
  logic [23:0] win_base;
  int unsigned win_count;
  bit          has_word;
  int unsigned word_first;
  int unsigned word_end;
  bit          gap_seen;
  int unsigned gap_at;
  int unsigned gap_word_end;
  term_stage_t term_stage;
  bit          stop_pending;

  scs_pkg::out_item_t step_pieces[$];
  scs_pkg::out_item_t pieces_due[$];
  scs_pkg::in_item_t  feed_q[$];

  bit       in_took = 1'b0;
  int       bad = 0;
  int       pieces_seen = 0;
  int       bytes_in = 0;
  int       texts_done = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_FREE;

  function automatic void add_piece(logic [23:0] s, int unsigned len);
    scs_pkg::out_item_t pc;
    if (step_pieces.size() >= 2 || len == 0) return;
    pc.piece_start = s;
    pc.piece_length = scs_pkg::LEN_BITS'(len);
    pc.piece_end_of_burst = 1'b0;
    step_pieces.insert(step_pieces.size(), pc);
  endfunction

  function automatic void close_window();
    if (win_open && has_word) add_piece(win_base + 24'(word_first), word_end - word_first);
    win_open = 1'b0;
    has_word = 1'b0;
    gap_seen = 1'b0;
    win_count = 0;
  endfunction

  function automatic void start_window(logic [23:0] p, bit blank_b);
    win_open = 1'b1;
    win_base = p;
    win_count = 1;
    word_first = 0;
    has_word = !blank_b;
    word_end = blank_b ? 0 : 1;
    gap_seen = 1'b0;
  endfunction

  function automatic void clear_text();
    next_pos = '0;
    win_open = 1'b0;
    win_base = '0;
    win_count = 0;
    has_word = 1'b0;
    word_first = 0;
    word_end = 0;
    gap_seen = 1'b0;
    gap_at = 0;
    gap_word_end = 0;
    term_stage = TS_IDLE;
    stop_pending = 1'b0;
  endfunction

  function automatic void predict_byte(scs_pkg::in_item_t it);
    logic [7:0]         b;
    logic [23:0]        p;
    bit                 blank_b;
    bit                 ends;
    int unsigned        lim;
    int unsigned        d;
    int unsigned        rest;
    term_stage_t        stage;
    scs_pkg::out_item_t pc;
    b = it.text_byte;
    p = next_pos;
    lim = (piece_cap == 0) ? 1 : piece_cap;
    blank_b = (b == B_SPACE || b == B_TAB || b == B_LF || b == B_CR);
    step_pieces.delete();

    if (stop_pending) begin
      stop_pending = 1'b0;
      if (blank_b) close_window();
    end

    stage = term_stage;
    term_stage = TS_IDLE;
    ends = 1'b0;
    if (stage == TS_E3 && b == B_80) term_stage = TS_E3_80;
    else if (stage == TS_E3_80 && b == B_82) ends = 1'b1;
    else if (stage == TS_E0 && b == B_A5) term_stage = TS_E0_A5;
    else if (stage == TS_E0_A5 && b == B_A4) ends = 1'b1;
    else if (b == B_DOT || b == B_BANG || b == B_QUERY) ends = 1'b1;
    else if (b == B_E3) term_stage = TS_E3;
    else if (b == B_E0) term_stage = TS_E0;

    if (!win_open) begin
      if (!blank_b) start_window(p, 1'b0);
    end else if (win_count >= lim) begin
      d = win_count;
      if (!blank_b && gap_seen && gap_at < d) begin
        // split at the last blank, carrying the tail into a new window
        rest = d - gap_at;
        if (has_word && word_first < gap_at)
          add_piece(win_base + 24'(word_first), gap_word_end - word_first);
        win_base = win_base + 24'(gap_at);
        win_count = rest + 1;
        word_first = 1;
        word_end = rest + 1;
        has_word = 1'b1;
        gap_seen = 1'b0;
      end else begin
        if (has_word) add_piece(win_base + 24'(word_first), word_end - word_first);
        start_window(p, blank_b);
      end
    end else begin
      d = win_count;
      if (blank_b) begin
        if (d >= 2) begin
          gap_at = d;
          gap_word_end = word_end;
          gap_seen = 1'b1;
        end
      end else begin
        if (!has_word) begin
          word_first = d;
          has_word = 1'b1;
        end
        word_end = d + 1;
      end
      win_count = d + 1;
    end

    if (ends) stop_pending = 1'b1;
    next_pos = p + 24'd1;

    if (it.text_last) begin
      close_window();
      clear_text();
      texts_done++;
    end
    if (step_pieces.size() > 0) begin
      pc = step_pieces.pop_back();
      pc.piece_end_of_burst = 1'b1;
      step_pieces.insert(step_pieces.size(), pc);
    end
    foreach (step_pieces[i]) pieces_due.insert(pieces_due.size(), step_pieces[i]);
  endfunction

  // sender: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    scs_pkg::in_item_t nxt;
    logic              v;
    v = 1'b0;
    nxt = in_item;
    if (!(in_valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (feed_q.size() > 0) begin
        nxt = feed_q.pop_front();
        v = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      in_valid <= v;
      in_item <= nxt;
    end
  end

  // receiver stall pattern in one of four randomly chosen modes
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      RX_HEAVY:  out_stall <= (rx_tick % 10) < 7;
      default:   out_stall <= rx_tick[1];
    endcase
  end

  // check pieces, then predict for the byte taken at this edge
  always @(posedge clk) begin
    scs_pkg::out_item_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      pieces_seen++;
      if (pieces_due.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("unexpected piece: start %0d len %0d last %0b",
                   out_item.piece_start, out_item.piece_length, out_item.piece_end_of_burst);
      end else begin
        want = pieces_due.pop_front();
        if (out_item.piece_start !== want.piece_start ||
            out_item.piece_length !== want.piece_length ||
            out_item.piece_end_of_burst !== want.piece_end_of_burst) begin
          bad++;
          if (bad <= 10)
            $display("piece %0d mismatch: expected start %0d len %0d last %0b, got %0d %0d %0b",
                     pieces_seen, want.piece_start, want.piece_length,
                     want.piece_end_of_burst, out_item.piece_start,
                     out_item.piece_length, out_item.piece_end_of_burst);
        end
      end
    end
    if (in_took) begin
      predict_byte(in_item);
      bytes_in++;
    end
  end

  function automatic void put_byte(logic [7:0] b, bit last);
    scs_pkg::in_item_t it;
    it.text_byte = b;
    it.text_last = last;
    feed_q.insert(feed_q.size(), it);
  endfunction

  function automatic void put_str(string s, bit last);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], last && i == s.len() - 1);
  endfunction

  function automatic void mark_last();
    scs_pkg::in_item_t it;
    it = feed_q.pop_back();
    it.text_last = 1'b1;
    feed_q.insert(feed_q.size(), it);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0:       return B_TAB;
      1:       return B_LF;
      2:       return B_CR;
      default: return B_SPACE;
    endcase
  endfunction

  // random text: mostly words, blanks and terminators, with some noise
  function automatic void queue_texts(int n, bit close_at_end);
    int base;
    int wl;
    base = feed_q.size();
    while (feed_q.size() - base < n) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: begin
          wl = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 5);
          repeat (wl) begin
            if ($urandom_range(0, 9) == 0) begin
              put_byte(8'hC3, 1'b0);
              put_byte(8'hA9, 1'b0);
            end else begin
              put_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
            end
          end
        end
        5, 6, 7: repeat ($urandom_range(1, 3)) put_byte(blank_byte(), 1'b0);
        8: begin
          case ($urandom_range(0, 4))
            0: put_byte(B_DOT, 1'b0);
            1: put_byte(B_BANG, 1'b0);
            2: put_byte(B_QUERY, 1'b0);
            3: begin
              put_byte(B_E3, 1'b0);
              put_byte(B_80, 1'b0);
              put_byte(B_82, 1'b0);
            end
            default: begin
              put_byte(B_E0, 1'b0);
              put_byte(B_A5, 1'b0);
              put_byte(B_A4, 1'b0);
            end
          endcase
          if ($urandom_range(0, 3) != 0) put_byte(blank_byte(), 1'b0);
        end
        9: begin
          put_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
          put_byte(B_DOT, 1'b0);
          put_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        end
        10: begin
          // truncated multi-byte terminators
          if ($urandom_range(0, 1) == 0) begin
            put_byte(B_E3, 1'b0);
            if ($urandom_range(0, 1) == 0) put_byte(B_80, 1'b0);
          end else begin
            put_byte(B_E0, 1'b0);
            if ($urandom_range(0, 1) == 0) put_byte(B_A5, 1'b0);
          end
          put_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        default: put_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
      if ($urandom_range(0, 13) == 0) mark_last();
    end
    if (close_at_end) mark_last();
  endfunction

  task automatic wait_drained();
    forever begin
      @(posedge clk);
      #1;
      if (feed_q.size() == 0 && !in_valid && pieces_due.size() == 0) break;
    end
  endtask

  // write the register, then read it back
  task automatic set_piece_cap(int unsigned v);
    logic [scs_pkg::CFG_DATA_W-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= scs_pkg::CFG_ADDR_W'(scs_pkg::REG_MAX_PIECE) << 2;
    pwdata <= scs_pkg::CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    piece_cap = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== scs_pkg::CFG_DATA_W'(v)) begin
      bad++;
      if (bad <= 10) $display("register read: expected %0d, got %0d", v, rd);
    end
  endtask

  initial begin
    int unsigned caps[7];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clear_text();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: blank kinds, byte extremes, decimal point, all terminators
    put_byte(8'h00, 1'b0);
    put_str("A.\t1.5 ", 1'b0);
    put_byte(8'hFF, 1'b0);
    put_str("?\r", 1'b0);
    put_byte(B_E3, 1'b0);
    put_byte(B_80, 1'b0);
    put_byte(B_82, 1'b0);
    put_byte(B_LF, 1'b0);
    put_byte(B_E0, 1'b0);
    put_byte(B_A5, 1'b0);
    put_byte(B_A4, 1'b0);
    put_str(" !", 1'b1);
    wait_drained();
    repeat (4) @(posedge clk);

    // directed: blank split then mid-word split
    set_piece_cap(3);
    put_str("ab cdef", 1'b1);
    wait_drained();
    repeat (4) @(posedge clk);

    caps = '{1, 65535, 2, 5, 9, 16, 0};
    caps[6] = $urandom_range(3, 40);
    foreach (caps[i]) begin
      set_piece_cap(caps[i]);
      // an open text at the end of a phase carries over into the next setting
      queue_texts(42, i == 6 || $urandom_range(0, 1) == 0);
      wait_drained();
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    $display("%0d bytes in %0d texts over 9 piece-length settings; %0d pieces checked",
             bytes_in, texts_done, pieces_seen);
    if (bad == 0 && pieces_due.size() == 0) begin
      $display("tb_sentence_chunk_splitter passed");
    end else begin
      $display("tb_sentence_chunk_splitter failed");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("tb_sentence_chunk_splitter failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/scs_pkg.sv
hw/rtl/scs_cfg.sv
hw/rtl/scs_core.sv
hw/rtl/scs_fifo.sv
hw/rtl/sentence_chunk_splitter.sv
test/tb_sentence_chunk_splitter.sv
